// ===== hdl/mic_calibration_dc_blocker_top_assert.svh =====
// Assertion macros for the microphone calibration DC blocker.
// Used by the port checker; needs nothing else.
`ifndef MIC_CALIBRATION_DC_BLOCKER_TOP_ASSERT_SVH
`define MIC_CALIBRATION_DC_BLOCKER_TOP_ASSERT_SVH

// clocked property, off while reset is asserted
`define MCDC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mcdc assertion failed");

// clocked property, also checked through reset
`define MCDC_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mcdc reset assertion failed");

`endif

// ===== hdl/mcdc_pkg.sv =====
// Shared types, constants and helpers for the microphone calibration DC blocker.
// No dependencies.
`default_nettype none

package mcdc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int NUM_CH      = 6;
    localparam int CHANNELS_DEF = 6;
    localparam int COEF_BITS   = 16;
    localparam int CFG_BITS    = 48;
    localparam int IDX_BITS    = 3;
    localparam int SAT_W       = SAMPLE_BITS + 8;

    localparam logic [5:0]          POLARITY_RST = 6'd0;
    localparam logic [CFG_BITS-1:0] GAINS_RST    = 48'h4000_4000_4000;
    localparam logic [CFG_BITS-1:0] OFFSETS_RST  = 48'h0;
    localparam logic [COEF_BITS-1:0] POLE_RST    = 16'd65365;

    localparam logic signed [SAT_W-1:0] SAT_MAX =
        {{(SAT_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_MIN =
        {{(SAT_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [IDX_BITS-1:0] {
        CFG_POLARITY   = 3'd0,
        CFG_GAINS_LO   = 3'd1,
        CFG_GAINS_HI   = 3'd2,
        CFG_OFFSETS_LO = 3'd3,
        CFG_OFFSETS_HI = 3'd4,
        CFG_POLE       = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_5;
        logic signed [SAMPLE_BITS-1:0] sample_4;
        logic signed [SAMPLE_BITS-1:0] sample_3;
        logic signed [SAMPLE_BITS-1:0] sample_2;
        logic signed [SAMPLE_BITS-1:0] sample_1;
        logic signed [SAMPLE_BITS-1:0] sample_0;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_5;
        logic signed [SAMPLE_BITS-1:0] out_4;
        logic signed [SAMPLE_BITS-1:0] out_3;
        logic signed [SAMPLE_BITS-1:0] out_2;
        logic signed [SAMPLE_BITS-1:0] out_1;
        logic signed [SAMPLE_BITS-1:0] out_0;
    } t_out_beat;

    typedef struct packed {
        logic load_x;
        logic load_y;
    } t_lane_ctl;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SAT_W-1:0] v
    );
        priority if (v > SAT_MAX) begin
            return SAT_MAX[SAMPLE_BITS-1:0];
        end else if (v < SAT_MIN) begin
            return SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            return v[SAMPLE_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mcdc_lane.sv =====
// One channel: offset, polarity, gain and saturation, then the DC blocker.
// Depends on mcdc_pkg.
`default_nettype none

module mcdc_lane
    import mcdc_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_lane_ctl                     i_ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [COEF_BITS-1:0]          i_offset,
    input  wire logic [COEF_BITS-1:0]          i_gain,
    input  wire logic                          i_invert,
    input  wire logic [COEF_BITS-1:0]          i_pole,
    output logic signed [SAMPLE_BITS-1:0]      o_y
);

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PX_W   = DIFF_W + COEF_BITS + 1;
    localparam int XR_W   = PX_W - 14;
    localparam int PF_W   = SAMPLE_BITS + COEF_BITS + 1;
    localparam int FB_W   = PF_W - 16;
    localparam int SUM_W  = SAMPLE_BITS + 3;

    localparam logic signed [PX_W-1:0] ROUND_X = PX_W'(1) <<< 13;
    localparam logic signed [PF_W-1:0] ROUND_F = PF_W'(1) <<< 15;

    logic signed [DIFF_W-1:0]      diff;
    logic signed [DIFF_W-1:0]      diff_pol;
    logic signed [PX_W-1:0]        prod_x;
    logic signed [PX_W-1:0]        prod_x_rnd;
    logic signed [XR_W-1:0]        x_wide;
    logic signed [SAMPLE_BITS-1:0] n_x;
    logic signed [PF_W-1:0]        prod_f;
    logic signed [PF_W-1:0]        prod_f_rnd;
    logic signed [FB_W-1:0]        fb;
    logic signed [SUM_W-1:0]       y_sum;
    logic signed [SAMPLE_BITS-1:0] n_y;

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_px;
    logic signed [SAMPLE_BITS-1:0] r_y;

    always_comb begin
        diff = DIFF_W'(i_sample) - DIFF_W'($signed(i_offset));
        diff_pol = i_invert ? -diff : diff;
        prod_x = PX_W'(diff_pol) * PX_W'($signed({1'b0, i_gain}));
        prod_x_rnd = prod_x + ROUND_X;
        x_wide = prod_x_rnd[PX_W-1:14];
        n_x = sat_sample(SAT_W'(x_wide));
    end

    always_comb begin
        prod_f = PF_W'($signed({1'b0, i_pole})) * PF_W'(r_y);
        prod_f_rnd = prod_f + ROUND_F;
        fb = prod_f_rnd[PF_W-1:16];
        y_sum = SUM_W'(r_x) - SUM_W'(r_px) + SUM_W'(fb);
        n_y = sat_sample(SAT_W'(y_sum));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_x) begin
            r_x <= n_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_y  <= '0;
        end else if (i_ctl.load_y) begin
            r_px <= r_x;
            r_y  <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

`default_nettype wire

// ===== hdl/mic_calibration_dc_blocker_top.sv =====
// Six-channel mic calibration (offset, polarity, gain) with a one-pole DC blocker.
// Pipeline: an accepted frame is registered in the input stage (r_x), then in the
// output stage (r_y); a stall on the output can hold it in either stage.
// Throughput: one frame per cycle when the output is not stalled; the filter stage closes
// its feedback (pole multiply, add, saturate) in combinational logic ahead of r_y.
// Reset (sync, active low) clears both stage valids, filter state and
// restores configuration defaults.
`default_nettype none

module mic_calibration_dc_blocker_top
    import mcdc_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire t_in_beat              i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output t_out_beat                  o_out_data,
    input  wire logic                  i_out_stall,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [CFG_BITS-1:0]   i_cfg_data
);

    logic [5:0]           r_polarity;
    logic [CFG_BITS-1:0]  r_gains_lo;
    logic [CFG_BITS-1:0]  r_gains_hi;
    logic [CFG_BITS-1:0]  r_offsets_lo;
    logic [CFG_BITS-1:0]  r_offsets_hi;
    logic [COEF_BITS-1:0] r_pole;

    logic r_xv;
    logic r_ov;
    logic n_xv;
    logic n_ov;
    logic in_accept;
    logic advance;
    t_lane_ctl lane_ctl;

    logic [NUM_CH*SAMPLE_BITS-1:0] in_flat;
    logic [NUM_CH*SAMPLE_BITS-1:0] out_flat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polarity   <= POLARITY_RST;
            r_gains_lo   <= GAINS_RST;
            r_gains_hi   <= GAINS_RST;
            r_offsets_lo <= OFFSETS_RST;
            r_offsets_hi <= OFFSETS_RST;
            r_pole       <= POLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_POLARITY:   r_polarity   <= i_cfg_data[5:0];
                CFG_GAINS_LO:   r_gains_lo   <= i_cfg_data;
                CFG_GAINS_HI:   r_gains_hi   <= i_cfg_data;
                CFG_OFFSETS_LO: r_offsets_lo <= i_cfg_data;
                CFG_OFFSETS_HI: r_offsets_hi <= i_cfg_data;
                CFG_POLE:       r_pole       <= i_cfg_data[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        advance    = r_xv && (!r_ov || !i_out_stall);
        o_in_stall = r_xv && !advance;
        in_accept  = i_in_valid && !o_in_stall;
        n_xv       = in_accept || (r_xv && !advance);
        n_ov       = advance || (r_ov && i_out_stall);
        lane_ctl   = '{load_x: in_accept, load_y: advance};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_xv <= n_xv;
            r_ov <= n_ov;
        end
    end

    assign in_flat = i_in_data;

    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        localparam int Slot = c % 3;
        if (c < CHANNELS) begin : g_lane
            logic [COEF_BITS-1:0] gain;
            logic [COEF_BITS-1:0] offset;
            if (c < 3) begin : g_lo
                assign gain   = r_gains_lo[COEF_BITS*Slot +: COEF_BITS];
                assign offset = r_offsets_lo[COEF_BITS*Slot +: COEF_BITS];
            end else begin : g_hi
                assign gain   = r_gains_hi[COEF_BITS*Slot +: COEF_BITS];
                assign offset = r_offsets_hi[COEF_BITS*Slot +: COEF_BITS];
            end
            mcdc_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (lane_ctl),
                .i_sample ($signed(in_flat[SAMPLE_BITS*c +: SAMPLE_BITS])),
                .i_offset (offset),
                .i_gain   (gain),
                .i_invert (r_polarity[c]),
                .i_pole   (r_pole),
                .o_y      (out_flat[SAMPLE_BITS*c +: SAMPLE_BITS])
            );
        end else begin : g_unused
            assign out_flat[SAMPLE_BITS*c +: SAMPLE_BITS] = '0;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = out_flat;

endmodule

`default_nettype wire

// ===== hdl/mcdc_checker.sv =====
// Port-level checker for the DC blocker top, bound to it below.
// Depends on mcdc_pkg and mic_calibration_dc_blocker_top_assert.svh.
`default_nettype none

`include "mic_calibration_dc_blocker_top_assert.svh"

module mcdc_checker
    import mcdc_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire t_out_beat           o_out_data,
    input wire logic                i_out_stall
);

    `MCDC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
    `MCDC_ASSERT(a_stall_from_out, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall)
    `MCDC_ASSERT(a_rise_latency, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
    `MCDC_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall)

endmodule

bind mic_calibration_dc_blocker_top mcdc_checker u_mcdc_checker (.*);

`default_nettype wire
